// ----- hw/rtl/ipfrt_pkg.sv -----
// Shared types and codes for the IP fragment reassembly tracker.
// No dependencies; used by the tracker top level and its testbench.
`timescale 1ns / 1ps
package ipfrt_pkg;

   typedef enum logic [2:0] {
      ST_SUCCESS   = 3'd0,
      ST_COMPLETE  = 3'd1,
      ST_DUPLICATE = 3'd2,
      ST_INVALID   = 3'd3,
      ST_NO_MEMORY = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_SCAN_RD,
      FSM_SCAN_CHK,
      FSM_CHECK,
      FSM_SH_RD,
      FSM_SH_WR,
      FSM_INSERT,
      FSM_FINISH
   } fsm_type;

   typedef struct packed {
      logic [31:0] header_handle;
      logic [15:0] header_len;
      logic [31:0] packet_id;
      logic [63:0] arrival_time;
      logic [15:0] frag_offset;
      logic [31:0] payload_handle;
      logic [15:0] payload_len;
      logic        is_final;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [6:0]  fragment_count;
      logic [15:0] total_length;
      logic [5:0]  slot_position;
      logic [31:0] saved_id;
      logic [63:0] saved_time;
   } rsp_type;

   // One stored fragment extent: 33 bits
   typedef struct packed {
      logic        fin;
      logic [15:0] len;
      logic [15:0] off;
   } extent_type;

   localparam int unsigned ExtentWidth = $bits(extent_type);
   localparam int unsigned HandleWidth = 32;

endpackage

// ----- hw/rtl/ip_fragment_reassembly_tracker_unit.sv -----
// Top level of the IP fragment reassembly tracker.
// Depends on ipfrt_pkg and ipfrt_ram.
//
// Usage: drive req with one fragment descriptor and pulse start while busy is
// low; the beat is taken at that edge and busy rises. When the work ends, rsp
// carries one result for exactly one cycle, marked by rsp_strobe, and busy
// drops in that same cycle. The receiver cannot stall; the result must be
// captured on the strobe cycle.
// In operation, the downward scan reads and compares one stored entry at a
// time; a scan that passes, or reaches the bottom of the table, leads to the
// size and room check; a stored fragment then shifts each entry at or above
// its slot up by one, opens the slot and writes it. Every path ends in the
// finish step that issues the result; a fragment rejected by the scan or the
// check goes straight there. Each fragment memory has one read port, visited
// once per entry in both passes. One fragment is in flight at a time.
// csr_wr_en/csr_wr_data write packet_limit; write only while busy is low.
// Reset clears the fragment count, the length sum and the saved header state;
// packet_limit returns to 65535. Table memories need no clearing since only
// entries below the fragment count are ever read.
`timescale 1ns / 1ps
module ip_fragment_reassembly_tracker_unit #(
   parameter int unsigned TABLE_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ipfrt_pkg::req_type req,
   output logic              rsp_strobe,
   output ipfrt_pkg::rsp_type rsp,
   input  logic              csr_wr_en,
   input  logic [15:0]       csr_wr_data
);

   localparam int unsigned AW = $clog2(TABLE_DEPTH);
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] FullCount = CW'(TABLE_DEPTH);
   localparam logic [CW-1:0] OneCount  = CW'(1);

   ipfrt_pkg::fsm_type    state_ff, state_in;
   ipfrt_pkg::req_type    req_ff, req_in;
   ipfrt_pkg::status_type status_ff, status_in;
   ipfrt_pkg::extent_type top_ff, top_in, cur, new_ext;
   logic                  accepted_ff, accepted_in;
   logic [CW-1:0]         used_ff, used_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [CW-1:0]         sp_ff, sp_in;
   logic [15:0]           lsum_ff, lsum_in;
   logic [15:0]           limit_ff;
   logic [15:0]           shlen_ff, shlen_in;
   logic [31:0]           shandle_ff, shandle_in;
   logic [31:0]           sid_ff, sid_in;
   logic [63:0]           stime_ff, stime_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   ipfrt_pkg::rsp_type    rsp_ff, rsp_in;

   // Memory ports
   logic                  mem_rd_en, mem_wr_en;
   logic [AW-1:0]         mem_rd_addr, mem_wr_addr;
   logic [ipfrt_pkg::ExtentWidth-1:0] ext_wr_data, ext_rd_data;
   logic [ipfrt_pkg::HandleWidth-1:0] hdl_wr_data, hdl_rd_data;

   // Arithmetic helpers
   logic [16:0]   cur_end, new_end, top_end;
   logic [15:0]   hdr_len;
   logic [17:0]   size_sum;
   logic [CW-1:0] ptr_m1;
   logic [CW+6:0] count_ext;
   logic [CW+5:0] slot_ext;

   ipfrt_ram #(.WIDTH(ipfrt_pkg::ExtentWidth), .DEPTH(TABLE_DEPTH)) u_ext_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (ext_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (ext_rd_data)
   );

   ipfrt_ram #(.WIDTH(ipfrt_pkg::HandleWidth), .DEPTH(TABLE_DEPTH)) u_hdl_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (hdl_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (hdl_rd_data)
   );

   assign cur      = ipfrt_pkg::extent_type'(ext_rd_data);
   assign new_ext  = '{fin: req_ff.is_final, len: req_ff.payload_len, off: req_ff.frag_offset};
   assign cur_end  = {1'b0, cur.off} + {1'b0, cur.len};
   assign new_end  = {1'b0, req_ff.frag_offset} + {1'b0, req_ff.payload_len};
   assign top_end  = {1'b0, top_ff.off} + {1'b0, top_ff.len};
   assign hdr_len  = (shlen_ff != 16'd0) ? shlen_ff : req_ff.header_len;
   assign size_sum = {2'b00, hdr_len} + {2'b00, lsum_ff} + {2'b00, req_ff.payload_len};

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ipfrt_pkg::FSM_IDLE;
         used_ff       <= '0;
         lsum_ff       <= '0;
         limit_ff      <= 16'hFFFF;
         shlen_ff      <= '0;
         shandle_ff    <= '0;
         sid_ff        <= '0;
         stime_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         lsum_ff       <= lsum_in;
         shlen_ff      <= shlen_in;
         shandle_ff    <= shandle_in;
         sid_ff        <= sid_in;
         stime_ff      <= stime_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      status_ff   <= status_in;
      top_ff      <= top_in;
      accepted_ff <= accepted_in;
      idx_ff      <= idx_in;
      sp_ff       <= sp_in;
      rsp_ff      <= rsp_in;
   end

   // Next state, table walk and result
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      status_in     = status_ff;
      top_in        = top_ff;
      accepted_in   = accepted_ff;
      used_in       = used_ff;
      idx_in        = idx_ff;
      sp_in         = sp_ff;
      lsum_in       = lsum_ff;
      shlen_in      = shlen_ff;
      shandle_in    = shandle_ff;
      sid_in        = sid_ff;
      stime_in      = stime_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      mem_rd_en     = 1'b0;
      mem_wr_en     = 1'b0;
      ptr_m1        = '0;
      mem_rd_addr   = '0;
      mem_wr_addr   = '0;
      ext_wr_data   = ext_rd_data;
      hdl_wr_data   = hdl_rd_data;
      count_ext     = '0;
      slot_ext      = '0;

      unique case (state_ff)
         ipfrt_pkg::FSM_IDLE: begin
            if (start) begin
               req_in      = req;
               idx_in      = used_ff;
               accepted_in = 1'b0;
               state_in    = ipfrt_pkg::FSM_SCAN_RD;
            end
         end
         ipfrt_pkg::FSM_SCAN_RD: begin
            // Read the entry just below the candidate slot
            if (idx_ff == '0) begin
               state_in = ipfrt_pkg::FSM_CHECK;
            end else begin
               ptr_m1      = idx_ff - OneCount;
               mem_rd_en   = 1'b1;
               mem_rd_addr = ptr_m1[AW-1:0];
               state_in    = ipfrt_pkg::FSM_SCAN_CHK;
            end
         end
         ipfrt_pkg::FSM_SCAN_CHK: begin
            // Place the new fragment against the stored one
            if (req_ff.frag_offset > cur.off) begin
               if (!cur.fin && cur_end <= {1'b0, req_ff.frag_offset}) begin
                  state_in = ipfrt_pkg::FSM_CHECK;
               end else begin
                  status_in = ipfrt_pkg::ST_INVALID;
                  state_in  = ipfrt_pkg::FSM_FINISH;
               end
            end else if (req_ff.frag_offset < cur.off) begin
               if (!req_ff.is_final && new_end <= {1'b0, cur.off}) begin
                  idx_in   = idx_ff - OneCount;
                  state_in = ipfrt_pkg::FSM_SCAN_RD;
               end else begin
                  status_in = ipfrt_pkg::ST_INVALID;
                  state_in  = ipfrt_pkg::FSM_FINISH;
               end
            end else begin
               status_in = (req_ff.payload_len == cur.len && req_ff.is_final == cur.fin) ?
                           ipfrt_pkg::ST_DUPLICATE : ipfrt_pkg::ST_INVALID;
               state_in  = ipfrt_pkg::FSM_FINISH;
            end
         end
         ipfrt_pkg::FSM_CHECK: begin
            // Size limit, then room in the table
            if (size_sum > {2'b00, limit_ff}) begin
               status_in = ipfrt_pkg::ST_INVALID;
               state_in  = ipfrt_pkg::FSM_FINISH;
            end else if (used_ff == FullCount) begin
               status_in = ipfrt_pkg::ST_NO_MEMORY;
               state_in  = ipfrt_pkg::FSM_FINISH;
            end else begin
               accepted_in = 1'b1;
               if (req_ff.frag_offset == 16'd0) begin
                  shandle_in = req_ff.header_handle;
                  shlen_in   = req_ff.header_len;
                  sid_in     = req_ff.packet_id;
                  stime_in   = req_ff.arrival_time;
               end else if (used_ff == '0) begin
                  sid_in   = req_ff.packet_id;
                  stime_in = req_ff.arrival_time;
               end
               sp_in    = used_ff;
               state_in = ipfrt_pkg::FSM_SH_RD;
            end
         end
         ipfrt_pkg::FSM_SH_RD: begin
            // Fetch the next entry to move up, or open the slot
            if (sp_ff > idx_ff) begin
               ptr_m1      = sp_ff - OneCount;
               mem_rd_en   = 1'b1;
               mem_rd_addr = ptr_m1[AW-1:0];
               state_in    = ipfrt_pkg::FSM_SH_WR;
            end else begin
               state_in = ipfrt_pkg::FSM_INSERT;
            end
         end
         ipfrt_pkg::FSM_SH_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = sp_ff[AW-1:0];
            sp_in       = sp_ff - OneCount;
            state_in    = ipfrt_pkg::FSM_SH_RD;
         end
         ipfrt_pkg::FSM_INSERT: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = idx_ff[AW-1:0];
            ext_wr_data = new_ext;
            hdl_wr_data = req_ff.payload_handle;
            if (idx_ff == used_ff) begin
               top_in = new_ext;
            end
            used_in  = used_ff + OneCount;
            lsum_in  = lsum_ff + req_ff.payload_len;
            state_in = ipfrt_pkg::FSM_FINISH;
         end
         ipfrt_pkg::FSM_FINISH: begin
            // Issue the result beat
            count_ext = {7'd0, used_ff};
            slot_ext  = {6'd0, idx_ff};
            rsp_in.fragment_count = count_ext[6:0];
            rsp_in.total_length   = lsum_ff;
            rsp_in.saved_id       = sid_ff;
            rsp_in.saved_time     = stime_ff;
            if (accepted_ff) begin
               rsp_in.slot_position = slot_ext[5:0];
               rsp_in.status = (!top_ff.fin || {1'b0, lsum_ff} < top_end) ?
                               ipfrt_pkg::ST_SUCCESS : ipfrt_pkg::ST_COMPLETE;
            end else begin
               rsp_in.slot_position = 6'd0;
               rsp_in.status        = status_ff;
            end
            rsp_strobe_in = 1'b1;
            state_in      = ipfrt_pkg::FSM_IDLE;
         end
         default: begin
            state_in = ipfrt_pkg::FSM_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != ipfrt_pkg::FSM_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

   // Table never holds more than its depth
   assert property (@(posedge clock) disable iff (reset) used_ff <= FullCount)
      else $error("fragment count exceeds table depth");

   // An accepted beat keeps the block busy in the next cycle
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("start beat not taken");

   // An insertion result always reports a non-empty table
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp.status == ipfrt_pkg::ST_SUCCESS ||
                      rsp.status == ipfrt_pkg::ST_COMPLETE)) |-> (used_ff != '0))
      else $error("insert result with empty table");

   // A result beat appears only as the walk ends
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ipfrt_pkg::FSM_FINISH))
      else $error("result beat without finish");

endmodule

// ----- hw/rtl/ipfrt_ram.sv -----
// Single-port-write, single-port-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module ipfrt_ram #(
   parameter int unsigned WIDTH = 33,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Register read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- dv/ip_fragment_reassembly_tracker_unit_test.sv -----
// Self-checking testbench for the IP fragment reassembly tracker.
// Depends on ipfrt_pkg and ip_fragment_reassembly_tracker_unit; a local fragment
// table model predicts each result beat, which is checked field by field.
`timescale 1ns / 1ps
module ip_fragment_reassembly_tracker_unit_test;

   localparam int TableDepth = 64;
   localparam int PlanSlots = 64;
   localparam longint CycleLimit = 1000000;

   typedef struct {
      bit                 is_csr;
      logic [15:0]        limit_value;
      int                 gap_pct;
      ipfrt_pkg::req_type frag;
   } stim_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   ipfrt_pkg::req_type req;
   logic               rsp_strobe;
   ipfrt_pkg::rsp_type rsp;
   logic               csr_wr_en;
   logic [15:0]        csr_wr_data;

   ip_fragment_reassembly_tracker_unit uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req(req),
      .rsp_strobe(rsp_strobe), .rsp(rsp), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   stim_type           pending_beats[$];
   ipfrt_pkg::rsp_type expected_results[$];
   int          mismatches = 0;
   longint      cycles = 0;

   // Fragment table model
   int unsigned tab_off [TableDepth];
   int unsigned tab_len [TableDepth];
   bit          tab_fin [TableDepth];
   int unsigned frag_total = 0;
   int unsigned length_total = 0;
   int unsigned header_len_kept = 0;
   logic [31:0] id_kept = '0;
   logic [63:0] time_kept = '0;
   int unsigned size_limit = 65535;

   // Datagram layout used by the stimulus
   int unsigned plan_off [PlanSlots];
   int unsigned plan_len [PlanSlots];

   function automatic ipfrt_pkg::rsp_type track_fragment(ipfrt_pkg::req_type f);
      int unsigned off, len, hdr, pos, c;
      bit fin, rejected;
      ipfrt_pkg::status_type st;
      ipfrt_pkg::rsp_type r;
      off = f.frag_offset;
      len = f.payload_len;
      fin = f.is_final;
      pos = frag_total;
      rejected = 0;
      st = ipfrt_pkg::ST_SUCCESS;
      // scan down from the top entry for the insertion slot
      while (pos > 0) begin
         c = pos - 1;
         if (off > tab_off[c]) begin
            if (!tab_fin[c] && tab_off[c] + tab_len[c] <= off) break;
            st = ipfrt_pkg::ST_INVALID;
            rejected = 1;
            break;
         end else if (off < tab_off[c]) begin
            if (!fin && off + len <= tab_off[c]) begin
               pos--;
            end else begin
               st = ipfrt_pkg::ST_INVALID;
               rejected = 1;
               break;
            end
         end else begin
            st = (len == tab_len[c] && fin == tab_fin[c]) ?
                 ipfrt_pkg::ST_DUPLICATE : ipfrt_pkg::ST_INVALID;
            rejected = 1;
            break;
         end
      end
      if (!rejected) begin
         hdr = (header_len_kept != 0) ? header_len_kept : int'(f.header_len);
         if (hdr + length_total + len > size_limit) begin
            st = ipfrt_pkg::ST_INVALID;
            rejected = 1;
         end else if (frag_total >= TableDepth) begin
            st = ipfrt_pkg::ST_NO_MEMORY;
            rejected = 1;
         end
      end
      if (!rejected) begin
         if (off == 0) begin
            header_len_kept = f.header_len;
            id_kept = f.packet_id;
            time_kept = f.arrival_time;
         end else if (frag_total == 0) begin
            id_kept = f.packet_id;
            time_kept = f.arrival_time;
         end
         // shift later entries up and insert
         for (int i = frag_total; i > pos; i--) begin
            tab_off[i] = tab_off[i-1];
            tab_len[i] = tab_len[i-1];
            tab_fin[i] = tab_fin[i-1];
         end
         tab_off[pos] = off;
         tab_len[pos] = len;
         tab_fin[pos] = fin;
         frag_total++;
         length_total = (length_total + len) & 16'hFFFF;
         c = frag_total - 1;
         if (tab_fin[c] && length_total >= tab_off[c] + tab_len[c]) st = ipfrt_pkg::ST_COMPLETE;
         else st = ipfrt_pkg::ST_SUCCESS;
      end
      r.status = st;
      r.fragment_count = frag_total[6:0];
      r.total_length = length_total[15:0];
      r.slot_position = rejected ? 6'd0 : pos[5:0];
      r.saved_id = id_kept;
      r.saved_time = time_kept;
      return r;
   endfunction

   function automatic ipfrt_pkg::req_type make_frag(int unsigned off, int unsigned len, bit fin);
      ipfrt_pkg::req_type f;
      f.header_handle = $urandom;
      f.header_len = 16'd20;
      f.packet_id = $urandom;
      f.arrival_time = {$urandom, $urandom};
      f.frag_offset = off[15:0];
      f.payload_handle = $urandom;
      f.payload_len = len[15:0];
      f.is_final = fin;
      return f;
   endfunction

   // Noise: fully random beats, repeats of planned slots, bent lengths, stray offsets
   function automatic ipfrt_pkg::req_type noise_frag();
      ipfrt_pkg::req_type f;
      int unsigned k;
      k = $urandom_range(0, PlanSlots - 1);
      case ($urandom_range(0, 3))
         0: begin
            f = make_frag($urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 1));
            f.header_len = $urandom_range(0, 65535);
         end
         1: f = make_frag(plan_off[k], plan_len[k], k == PlanSlots - 1);
         2: f = make_frag(plan_off[k], $urandom_range(0, 60), $urandom_range(0, 1));
         default: f = make_frag($urandom_range(0, plan_off[PlanSlots-1] + 100),
                                $urandom_range(0, 50), $urandom_range(0, 1));
      endcase
      return f;
   endfunction

   task automatic queue_frag(ipfrt_pkg::req_type f, int gap);
      stim_type s;
      s.is_csr = 0;
      s.limit_value = '0;
      s.gap_pct = gap;
      s.frag = f;
      pending_beats.push_back(s);
   endtask

   task automatic queue_limit(int unsigned value);
      stim_type s;
      s.is_csr = 1;
      s.limit_value = value[15:0];
      s.gap_pct = 0;
      s.frag = '0;
      pending_beats.push_back(s);
   endtask

   task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v,
                              ref bit bad);
      if (exp_v !== act_v) begin
         bad = 1;
         if (mismatches < 10)
            $display("mismatch %s: expected %0h got %0h at %0t", name, exp_v, act_v, $realtime);
      end
   endtask

   // Clock and reset
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1;
      repeat (10) @(posedge clock);
      reset <= 0;
   end

   // Driver: issue the head of the pending queue, apply register writes when idle
   always @(posedge clock) begin
      logic               nxt_start, nxt_wr;
      ipfrt_pkg::req_type nxt_req;
      bit                 taken;
      nxt_start = start;
      nxt_wr = 0;
      nxt_req = req;
      taken = 0;
      if (reset) begin
         nxt_start = 0;
      end else begin
         if (start && !busy) begin
            expected_results.push_back(track_fragment(pending_beats[0].frag));
            void'(pending_beats.pop_front());
            taken = 1;
         end
         if (taken || !start) begin
            nxt_start = 0;
            if (pending_beats.size() > 0) begin
               if (pending_beats[0].is_csr) begin
                  // write only with nothing in flight
                  if (!taken && !busy && !csr_wr_en && expected_results.size() == 0) begin
                     nxt_wr = 1;
                     csr_wr_data <= pending_beats[0].limit_value;
                     size_limit = pending_beats[0].limit_value;
                     void'(pending_beats.pop_front());
                  end
               end else if ($urandom_range(0, 99) >= pending_beats[0].gap_pct) begin
                  nxt_start = 1;
                  nxt_req = pending_beats[0].frag;
               end
            end
         end
      end
      start <= nxt_start;
      csr_wr_en <= nxt_wr;
      req <= nxt_req;
   end

   // Monitor: compare each result beat with the oldest prediction
   always @(posedge clock) begin
      ipfrt_pkg::rsp_type want;
      bit bad;
      if (!reset && rsp_strobe) begin
         bad = 0;
         if (expected_results.size() == 0) begin
            bad = 1;
            if (mismatches < 10) $display("unexpected result beat at %0t", $realtime);
         end else begin
            want = expected_results.pop_front();
            check_field("status", want.status, rsp.status, bad);
            check_field("fragment_count", want.fragment_count, rsp.fragment_count, bad);
            check_field("total_length", want.total_length, rsp.total_length, bad);
            check_field("slot_position", want.slot_position, rsp.slot_position, bad);
            check_field("saved_id", want.saved_id, rsp.saved_id, bad);
            check_field("saved_time", want.saved_time, rsp.saved_time, bad);
         end
         if (bad) mismatches++;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CycleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int unsigned hold, order[$], tmp, j, need, sent;
      ipfrt_pkg::req_type f;
      start = 0;
      req = '0;
      csr_wr_en = 0;
      csr_wr_data = '0;

      // Lay out one datagram of contiguous slots, the last one final
      need = 0;
      for (int k = 0; k < PlanSlots; k++) begin
         plan_off[k] = need;
         plan_len[k] = $urandom_range(2, 40);
         need += plan_len[k];
      end
      hold = $urandom_range(2, PlanSlots - 2);

      // Directed part
      queue_limit(65535);
      f = '1;
      f.frag_offset = 100;
      f.payload_len = 1;
      f.is_final = 0;
      queue_frag(f, 36);                                  // oversize header, empty table
      queue_frag(make_frag(plan_off[1], plan_len[1], 0), 36); // first entry, not at offset zero
      f = make_frag(0, plan_len[0], 0);
      queue_frag(f, 36);                                  // offset zero keeps the header
      queue_frag(f, 36);                                  // exact repeat
      queue_frag(make_frag(0, plan_len[0] + 1, 0), 36);   // same offset, other length
      queue_frag(make_frag(plan_off[1] + 1, 1, 0), 36);   // overlap
      queue_frag(make_frag(plan_off[PlanSlots-1], plan_len[PlanSlots-1], 1), 36);
      queue_frag(make_frag(need + 5, 3, 0), 36);          // past the final fragment
      f = '1;
      queue_frag(f, 36);                                  // all ones
      queue_frag(make_frag(plan_off[2], plan_len[2], 1), 36); // final flag below the top
      queue_frag(make_frag(0, 0, 0), 36);                 // zero length
      queue_frag('0, 36);

      // Build the datagram in random order with noise, leaving one slot out
      for (int k = 2; k < PlanSlots - 1; k++) if (k != hold) order.push_back(k);
      for (int k = order.size() - 1; k > 0; k--) begin
         j = $urandom_range(0, k);
         tmp = order[k];
         order[k] = order[j];
         order[j] = tmp;
      end
      sent = 12;
      foreach (order[k]) begin
         if ($urandom_range(0, 99) < 30) begin
            queue_frag(noise_frag(), 36);
            sent++;
         end
         queue_frag(make_frag(plan_off[order[k]], plan_len[order[k]], 0), 36);
         sent++;
      end
      for (; sent < 250; sent++) queue_frag(noise_frag(), 36);

      // Zero limit: size check rejects every new fragment
      queue_limit(0);
      for (int k = 0; k < 350; k++) queue_frag(noise_frag(), 48);

      // Mid limit that still fits the datagram, then fill the held slot
      queue_limit($urandom_range(need + 20, 65535));
      if ($urandom_range(0, 1)) begin
         queue_frag(make_frag(plan_off[hold], plan_len[hold], 0), 0);
      end else begin
         queue_frag(make_frag(plan_off[hold], 1, 0), 0);
         queue_frag(make_frag(plan_off[hold] + 1, plan_len[hold] - 1, 0), 0);
         queue_frag(make_frag(plan_off[hold], plan_len[hold], 0), 0);
      end
      for (int k = 0; k < 450; k++) queue_frag(noise_frag(), 0);

      // Drain, then let stray beats show
      @(negedge reset);
      while (pending_beats.size() > 0 || expected_results.size() > 0) @(posedge clock);
      repeat (600) @(posedge clock);
      if (expected_results.size() != 0) mismatches++;
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
